// ===== design/elhr_pkg.sv =====
// shared types, constants and color stop tables for the elevation hsl ramp
`timescale 1ns / 1ps
`default_nettype none
package elhr_pkg;

    localparam int NUM_STOPS = 12;
    localparam int SEG_W     = 4;
    localparam int ELEV_W    = 18;
    localparam int OFS_W     = 16;
    localparam int RECIP_W   = 29;
    localparam int HUE_W     = 14;
    localparam int FRAC_W    = 16;

    typedef logic [SEG_W-1:0] seg_t;

    localparam seg_t NODATA_SEG = 4'd0;
    localparam seg_t CLAMP_SEG  = 4'd1;
    localparam seg_t LAST_SEG   = SEG_W'(NUM_STOPS - 1);

    typedef struct packed {
        logic signed [ELEV_W-1:0] pos;
        logic [HUE_W-1:0]         hue;
        logic [FRAC_W-1:0]        sat;
        logic [FRAC_W-1:0]        lig;
    } color_stop_t;

    // one queued transaction: segment and offset into it
    typedef struct packed {
        seg_t             seg;
        logic [OFS_W-1:0] ofs;
    } ramp_item_t;

    function automatic color_stop_t ramp_stop(input seg_t idx);
        color_stop_t st;
        case (idx)
            4'd0:    st = '{-18'sd60000, 14'd12800, 16'd22938, 16'd19661};
            4'd1:    st = '{-18'sd10,    14'd12800, 16'd29491, 16'd37356};
            4'd2:    st = '{18'sd0,      14'd0,     16'd1966,  16'd47186};
            4'd3:    st = '{18'sd200,    14'd0,     16'd2621,  16'd38011};
            4'd4:    st = '{18'sd800,    14'd2048,  16'd31457, 16'd39322};
            4'd5:    st = '{18'sd3000,   14'd4800,  16'd26214, 16'd31457};
            4'd6:    st = '{18'sd9000,   14'd7680,  16'd32768, 16'd16384};
            4'd7:    st = '{18'sd22000,  14'd6400,  16'd22938, 16'd38011};
            4'd8:    st = '{18'sd24000,  14'd512,   16'd36045, 16'd31457};
            4'd9:    st = '{18'sd27000,  14'd0,     16'd3277,  16'd36045};
            4'd10:   st = '{18'sd33000,  14'd3200,  16'd26214, 16'd45875};
            default: st = '{18'sd37760,  14'd0,     16'd0,     16'd62259};
        endcase
        return st;
    endfunction

    // round(2^32 / segment span)
    function automatic logic [RECIP_W-1:0] seg_recip(input seg_t idx);
        logic [RECIP_W-1:0] r;
        case (idx)
            4'd0:    r = 29'd71595;
            4'd1:    r = 29'd429496730;
            4'd2:    r = 29'd21474836;
            4'd3:    r = 29'd7158279;
            4'd4:    r = 29'd1952258;
            4'd5:    r = 29'd715828;
            4'd6:    r = 29'd330382;
            4'd7:    r = 29'd2147484;
            4'd8:    r = 29'd1431656;
            4'd9:    r = 29'd715828;
            4'd10:   r = 29'd902304;
            default: r = 29'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/elevation_hsl_ramp_landscape.sv =====
// top level of the elevation to rgb color ramp
// usage:
//   in_valid/in_ready/elevation carries one signed decimetre sample per
//   transaction; out_valid/out_ready/red/green/blue returns one pixel per
//   sample, in order.
//   cfg_valid/cfg_ready/cfg_data writes the no-data threshold; cfg_ready is
//   always high, and writes belong in idle periods.
// throughput: one sample per cycle sustained while out_ready is high.
// pipeline: an accepted sample is written to the queue at the accepting
//   edge, then passes through the nine-stage back end (segment fraction
//   multiply, interpolation multiplies, chroma multiply, sector select,
//   rounding and divide by 15), whose stages all advance together.
// stall: while a pixel waits at the output the back end freezes; the front
//   keeps taking samples into a QUEUE_DEPTH entry queue and drops in_ready
//   once that queue is full.
// reset: threshold returns to -90000, queue and pipeline are emptied, no
//   pixel is pending.
`timescale 1ns / 1ps
`default_nettype none
module elevation_hsl_ramp_landscape #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic signed [elhr_pkg::ELEV_W-1:0] cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [elhr_pkg::ELEV_W-1:0] elevation,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         red,
    output logic [7:0]                         green,
    output logic [7:0]                         blue
);
    import elhr_pkg::*;

    logic       push;
    logic       full;
    logic       pop;
    logic       not_empty;
    ramp_item_t push_item;
    ramp_item_t pop_item;

    elhr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .elevation (elevation),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    elhr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (not_empty)
    );

    elhr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (not_empty),
        .q_item    (pop_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

endmodule
`default_nettype wire

// ===== design/elhr_front.sv =====
// front end: threshold register, sample classification and segment search
`timescale 1ns / 1ps
`default_nettype none
module elhr_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic signed [elhr_pkg::ELEV_W-1:0] cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [elhr_pkg::ELEV_W-1:0] elevation,
    output logic                               push,
    output elhr_pkg::ramp_item_t               push_item,
    input  logic                               full
);
    import elhr_pkg::*;

    logic signed [ELEV_W-1:0] nodata_below_reg;
    logic signed [ELEV_W-1:0] nodata_below_next;
    color_stop_t              stop_i;
    color_stop_t              stop_last;
    logic signed [ELEV_W-1:0] cand_pos;
    logic signed [ELEV_W-1:0] base_pos;
    logic [ELEV_W:0]          diff;
    seg_t                     seg_sel;
    logic [OFS_W-1:0]         ofs_sel;

    assign cfg_ready = 1'b1;
    assign in_ready  = !full;
    assign push      = in_valid && !full;

    always_comb
    begin
        nodata_below_next = nodata_below_reg;
        if (cfg_valid)
        begin
            nodata_below_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodata_below_reg <= -18'sd90000;
        end
        else
        begin
            nodata_below_reg <= nodata_below_next;
        end
    end

    always_comb
    begin
        stop_last = ramp_stop(LAST_SEG);
        stop_i    = ramp_stop(NODATA_SEG);
        cand_pos  = stop_i.pos;
        base_pos  = stop_i.pos;
        seg_sel   = NODATA_SEG;
        ofs_sel   = '0;
        diff      = '0;
        if (elevation < nodata_below_reg)
        begin
            seg_sel = NODATA_SEG;
        end
        else if (elevation <= 18'sd0)
        begin
            // sea level and below sit exactly on the coastal stop
            seg_sel = CLAMP_SEG;
        end
        else if (elevation >= stop_last.pos)
        begin
            seg_sel = LAST_SEG;
        end
        else
        begin
            for (int i = 0; i < NUM_STOPS - 1; i++)
            begin
                stop_i   = ramp_stop(SEG_W'(i));
                cand_pos = stop_i.pos;
                if (elevation >= cand_pos)
                begin
                    seg_sel  = SEG_W'(i);
                    base_pos = cand_pos;
                end
            end
            diff    = {elevation[ELEV_W-1], elevation} - {base_pos[ELEV_W-1], base_pos};
            ofs_sel = diff[OFS_W-1:0];
        end
    end

    assign push_item.seg = seg_sel;
    assign push_item.ofs = ofs_sel;

endmodule
`default_nettype wire

// ===== design/elhr_queue.sv =====
// small fifo of classified transactions between front and back end
`timescale 1ns / 1ps
`default_nettype none
module elhr_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  elhr_pkg::ramp_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output elhr_pkg::ramp_item_t pop_item,
    output logic                 not_empty
);
    import elhr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ramp_item_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not shrink on pop");

endmodule
`default_nettype wire

// ===== design/elhr_back.sv =====
// back end: interpolation and hsl to rgb pipeline with output register
`timescale 1ns / 1ps
`default_nettype none
module elhr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  elhr_pkg::ramp_item_t q_item,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           red,
    output logic [7:0]           green,
    output logic [7:0]           blue
);
    import elhr_pkg::*;

    localparam int STAGES = 9;
    localparam int PROD_W = OFS_W + RECIP_W;
    localparam int DIF_W  = 34;
    localparam int CH_W   = 44;
    localparam int V_W    = 45;
    localparam int X_W    = 53;
    localparam int Y_W    = 13;
    localparam int Q_W    = 28;
    localparam logic [HUE_W-1:0] SEC1 = 14'd3840;
    localparam logic [HUE_W-1:0] SEC2 = 14'd7680;
    localparam logic [HUE_W-1:0] SEC3 = 14'd11520;
    localparam logic [HUE_W-1:0] SEC4 = 14'd15360;
    localparam logic [11:0]      SECTOR_LEN = 12'd3840;
    localparam logic [X_W-1:0]   HALF_DEN = X_W'(1920) << 32;
    // floor(y / 15) == (y * 17477) >> 18 for the y range seen here
    localparam logic [Q_W-1:0]   RECIP15 = Q_W'(17477);

    logic              adv;
    logic [STAGES-1:0] vld_reg;

    // stage 1
    logic [PROD_W-1:0] prod1_next, prod1_reg;
    seg_t              seg1_reg;
    // stage 2
    color_stop_t              stop_a2, stop_b2;
    seg_t                     seg_nxt;
    logic [FRAC_W-1:0]        t2;
    logic signed [FRAC_W:0]   tt2, dhd2, dsd2, dld2;
    logic signed [DIF_W-1:0]  dh2_next, ds2_next, dl2_next;
    logic signed [DIF_W-1:0]  dh2_reg, ds2_reg, dl2_reg;
    seg_t                     seg2_reg;
    // stage 3
    color_stop_t              stop_a3;
    logic signed [DIF_W-1:0]  hsum3, ssum3, lsum3;
    logic [HUE_W-1:0]         h3_reg;
    logic [FRAC_W-1:0]        s3_reg, l3_reg;
    // stage 4
    logic [FRAC_W:0]          twol4, dist4, span4;
    logic [31:0]              cnum4_next, cnum4_reg;
    logic [2:0]               k4_next, k4_reg;
    logic [HUE_W-1:0]         f4_full;
    logic [11:0]              f4, g4_next, g4_reg;
    logic [FRAC_W-1:0]        l4_reg;
    // stage 5
    logic [CH_W-1:0]          xx5_next, cc5_next, xx5_reg, cc5_reg;
    logic signed [33:0]       mq5_diff;
    logic [32:0]              mq5_next, mq5_reg;
    logic [2:0]               k5_reg;
    // stage 6
    logic [CH_W-1:0]          m6_next, qr6_next, qg6_next, qb6_next;
    logic [CH_W-1:0]          m6_reg, qr6_reg, qg6_reg, qb6_reg;
    // stage 7
    logic [V_W-1:0]           vr7_reg, vg7_reg, vb7_reg;
    // stage 8
    logic [X_W-1:0]           xr8, xg8, xb8;
    logic [Y_W-1:0]           yr8_reg, yg8_reg, yb8_reg;
    // stage 9
    logic [Q_W-1:0]           pr9, pg9, pb9;
    logic [7:0]               red_reg, green_reg, blue_reg;

    // whole pipeline moves unless the output register is held
    assign adv       = !vld_reg[STAGES-1] || out_ready;
    assign pop       = adv && q_valid;
    assign out_valid = vld_reg[STAGES-1];
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], q_valid};
        end
    end

    always_comb
    begin
        prod1_next = PROD_W'(q_item.ofs) * PROD_W'(seg_recip(q_item.seg));
    end

    always_comb
    begin
        seg_nxt  = (seg1_reg == LAST_SEG) ? seg1_reg : seg1_reg + 1'b1;
        stop_a2  = ramp_stop(seg1_reg);
        stop_b2  = ramp_stop(seg_nxt);
        t2       = (|prod1_reg[PROD_W-1:32]) ? '1 : prod1_reg[31:16];
        tt2      = $signed({1'b0, t2});
        dhd2     = $signed({3'b000, stop_b2.hue}) - $signed({3'b000, stop_a2.hue});
        dsd2     = $signed({1'b0, stop_b2.sat}) - $signed({1'b0, stop_a2.sat});
        dld2     = $signed({1'b0, stop_b2.lig}) - $signed({1'b0, stop_a2.lig});
        dh2_next = DIF_W'(dhd2) * DIF_W'(tt2);
        ds2_next = DIF_W'(dsd2) * DIF_W'(tt2);
        dl2_next = DIF_W'(dld2) * DIF_W'(tt2);
    end

    always_comb
    begin
        stop_a3 = ramp_stop(seg2_reg);
        hsum3   = $signed({20'b0, stop_a3.hue}) + ((dh2_reg + 34'sd32768) >>> 16);
        ssum3   = $signed({18'b0, stop_a3.sat}) + ((ds2_reg + 34'sd32768) >>> 16);
        lsum3   = $signed({18'b0, stop_a3.lig}) + ((dl2_reg + 34'sd32768) >>> 16);
    end

    always_comb
    begin
        twol4      = {l3_reg, 1'b0};
        dist4      = twol4[FRAC_W] ? twol4 - 17'd65536 : 17'd65536 - twol4;
        span4      = dist4[FRAC_W] ? '0 : 17'd65536 - dist4;
        cnum4_next = 32'({15'b0, span4} * {16'b0, s3_reg});
        if (h3_reg >= SEC4)
        begin
            k4_next = 3'd4;
            f4_full = h3_reg - SEC4;
        end
        else if (h3_reg >= SEC3)
        begin
            k4_next = 3'd3;
            f4_full = h3_reg - SEC3;
        end
        else if (h3_reg >= SEC2)
        begin
            k4_next = 3'd2;
            f4_full = h3_reg - SEC2;
        end
        else if (h3_reg >= SEC1)
        begin
            k4_next = 3'd1;
            f4_full = h3_reg - SEC1;
        end
        else
        begin
            k4_next = 3'd0;
            f4_full = h3_reg;
        end
        f4      = f4_full[11:0];
        g4_next = k4_next[0] ? SECTOR_LEN - f4 : f4;
    end

    always_comb
    begin
        xx5_next = CH_W'(cnum4_reg) * CH_W'(g4_reg);
        cc5_next = {cnum4_reg, 12'b0} - {4'b0, cnum4_reg, 8'b0};
        mq5_diff = $signed({1'b0, l4_reg, 17'b0}) - $signed({2'b0, cnum4_reg});
        mq5_next = mq5_diff[33] ? '0 : mq5_diff[32:0];
    end

    always_comb
    begin
        m6_next = {mq5_reg, 11'b0} - {4'b0, mq5_reg, 7'b0};
        case (k5_reg)
            3'd0:
            begin
                qr6_next = cc5_reg;
                qg6_next = xx5_reg;
                qb6_next = '0;
            end
            3'd1:
            begin
                qr6_next = xx5_reg;
                qg6_next = cc5_reg;
                qb6_next = '0;
            end
            3'd2:
            begin
                qr6_next = '0;
                qg6_next = cc5_reg;
                qb6_next = xx5_reg;
            end
            3'd3:
            begin
                qr6_next = '0;
                qg6_next = xx5_reg;
                qb6_next = cc5_reg;
            end
            3'd4:
            begin
                qr6_next = xx5_reg;
                qg6_next = '0;
                qb6_next = cc5_reg;
            end
            default:
            begin
                qr6_next = cc5_reg;
                qg6_next = '0;
                qb6_next = xx5_reg;
            end
        endcase
    end

    always_comb
    begin
        xr8 = (X_W'(vr7_reg) << 8) - X_W'(vr7_reg) + HALF_DEN;
        xg8 = (X_W'(vg7_reg) << 8) - X_W'(vg7_reg) + HALF_DEN;
        xb8 = (X_W'(vb7_reg) << 8) - X_W'(vb7_reg) + HALF_DEN;
        pr9 = Q_W'(yr8_reg) * RECIP15;
        pg9 = Q_W'(yg8_reg) * RECIP15;
        pb9 = Q_W'(yb8_reg) * RECIP15;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod1_reg <= prod1_next;
            seg1_reg  <= q_item.seg;
            dh2_reg   <= dh2_next;
            ds2_reg   <= ds2_next;
            dl2_reg   <= dl2_next;
            seg2_reg  <= seg1_reg;
            h3_reg    <= hsum3[HUE_W-1:0];
            s3_reg    <= ssum3[FRAC_W-1:0];
            l3_reg    <= lsum3[FRAC_W-1:0];
            cnum4_reg <= cnum4_next;
            k4_reg    <= k4_next;
            g4_reg    <= g4_next;
            l4_reg    <= l3_reg;
            xx5_reg   <= xx5_next;
            cc5_reg   <= cc5_next;
            mq5_reg   <= mq5_next;
            k5_reg    <= k4_reg;
            m6_reg    <= m6_next;
            qr6_reg   <= qr6_next;
            qg6_reg   <= qg6_next;
            qb6_reg   <= qb6_next;
            vr7_reg   <= V_W'(qr6_reg) + V_W'(m6_reg);
            vg7_reg   <= V_W'(qg6_reg) + V_W'(m6_reg);
            vb7_reg   <= V_W'(qb6_reg) + V_W'(m6_reg);
            yr8_reg   <= xr8[X_W-1:40];
            yg8_reg   <= xg8[X_W-1:40];
            yb8_reg   <= xb8[X_W-1:40];
            red_reg   <= (|pr9[Q_W-1:26]) ? 8'hFF : pr9[25:18];
            green_reg <= (|pg9[Q_W-1:26]) ? 8'hFF : pg9[25:18];
            blue_reg  <= (|pb9[Q_W-1:26]) ? 8'hFF : pb9[25:18];
        end
    end

endmodule
`default_nettype wire

// ===== verif/elevation_hsl_ramp_landscape_tb.sv =====
// self-checking testbench for the elevation to rgb color ramp
`timescale 1ns / 1ps
module elevation_hsl_ramp_landscape_tb;

    localparam int PIPE_LATENCY = 10;
    localparam int DRAIN_CYCLES = 3 * PIPE_LATENCY;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int IDLE_PCT     = 21;

    typedef logic signed [elhr_pkg::ELEV_W-1:0] elev_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        elev_t  elev;
        pixel_t px;
    } pixel_exp_t;

    typedef struct {
        int          pos;
        int unsigned hue;
        int unsigned sat;
        int unsigned lig;
    } hsl_stop_t;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  cfg_valid = 1'b0;
    logic  cfg_ready;
    elev_t cfg_data  = '0;
    logic  in_valid  = 1'b0;
    logic  in_ready;
    elev_t elevation = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    pixel_exp_t pixel_q[$];
    elev_t      nodata_thr = -18'sd90000;
    bit         idle_on    = 1'b1;
    logic       hold_token = 1'b0;
    logic       hold_seen;
    int         hold_cnt;
    int         cycle_cnt  = 0;
    int         err_cnt    = 0;
    int         sent_cnt   = 0;
    int         checked_cnt = 0;
    int         cfg_cnt    = 0;
    pixel_exp_t head;

    elevation_hsl_ramp_landscape DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .elevation (elevation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // color stops: position in dm, hue in 1/64 degree, sat and lightness q0.16
    function automatic hsl_stop_t stop_of(input int idx);
        hsl_stop_t st;
        case (idx)
            0:       st = '{-60000, 12800, 22938, 19661};
            1:       st = '{-10,    12800, 29491, 37356};
            2:       st = '{0,      0,     1966,  47186};
            3:       st = '{200,    0,     2621,  38011};
            4:       st = '{800,    2048,  31457, 39322};
            5:       st = '{3000,   4800,  26214, 31457};
            6:       st = '{9000,   7680,  32768, 16384};
            7:       st = '{22000,  6400,  22938, 38011};
            8:       st = '{24000,  512,   36045, 31457};
            9:       st = '{27000,  0,     3277,  36045};
            10:      st = '{33000,  3200,  26214, 45875};
            default: st = '{37760,  0,     0,     62259};
        endcase
        return st;
    endfunction

    function automatic logic [7:0] rgb_byte(input longint unsigned v,
                                            input longint unsigned denom);
        longint unsigned q;
        q = (v * 255 + denom / 2) / denom;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic pixel_t hsl_pixel(input longint unsigned h,
                                         input longint unsigned s,
                                         input longint unsigned l);
        longint unsigned twol, dev, span, cnum, denom, k, f, g;
        longint unsigned cc, xx, ll, half, m, rv, gv, bv;
        pixel_t px;
        twol  = 2 * l;
        dev   = (twol >= 65536) ? twol - 65536 : 65536 - twol;
        span  = (dev >= 65536) ? 0 : 65536 - dev;
        cnum  = span * s;
        denom = 64'd4294967296 * 3840;
        k     = h / 3840;
        f     = h % 3840;
        g     = k[0] ? 3840 - f : f;
        cc    = cnum * 3840;
        xx    = cnum * g;
        ll    = l * 65536 * 3840;
        half  = cnum * 1920;
        m     = (ll >= half) ? ll - half : 0;
        case (k)
            0:       begin rv = cc; gv = xx; bv = 0;  end
            1:       begin rv = xx; gv = cc; bv = 0;  end
            2:       begin rv = 0;  gv = cc; bv = xx; end
            3:       begin rv = 0;  gv = xx; bv = cc; end
            4:       begin rv = xx; gv = 0;  bv = cc; end
            default: begin rv = cc; gv = 0;  bv = xx; end
        endcase
        px.red   = rgb_byte(rv + m, denom);
        px.green = rgb_byte(gv + m, denom);
        px.blue  = rgb_byte(bv + m, denom);
        return px;
    endfunction

    function automatic longint unsigned blend16(input longint unsigned a,
                                                input longint unsigned b,
                                                input longint unsigned t);
        return (a * (65536 - t) + b * t + 32768) >> 16;
    endfunction

    function automatic pixel_t elevation_color(input elev_t sample, input elev_t thr);
        int e;
        int i;
        hsl_stop_t lo, hi;
        longint unsigned d, span, recip, t;
        e = sample;
        if (e < int'(thr))
        begin
            lo = stop_of(0);
            return hsl_pixel(lo.hue, lo.sat, lo.lig);
        end
        if (e <= 0)
            e = -10;
        for (i = 0; i < elhr_pkg::NUM_STOPS - 1; i++)
        begin
            lo = stop_of(i);
            hi = stop_of(i + 1);
            if (e >= lo.pos && e < hi.pos)
            begin
                span  = hi.pos - lo.pos;
                recip = (64'd4294967296 + span / 2) / span;
                d     = e - lo.pos;
                t     = (d * recip) >> 16;
                if (t > 65535)
                    t = 65535;
                return hsl_pixel(blend16(lo.hue, hi.hue, t),
                                 blend16(lo.sat, hi.sat, t),
                                 blend16(lo.lig, hi.lig, t));
            end
        end
        // summit and above
        hi = stop_of(elhr_pkg::NUM_STOPS - 1);
        return hsl_pixel(hi.hue, hi.sat, hi.lig);
    endfunction

    function automatic elev_t rand_elevation();
        int sel;
        hsl_stop_t st;
        sel = $urandom_range(0, 9);
        st  = stop_of($urandom_range(0, 11));
        case (sel)
            0, 1:    return elev_t'($urandom);
            7:       return elev_t'(st.pos + int'($urandom_range(0, 6)) - 3);
            8:       return elev_t'(-int'($urandom_range(0, 131072)));
            9:       return elev_t'($urandom_range(37700, 131071));
            default: return elev_t'($urandom_range(0, 37800));
        endcase
    endfunction

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycle_cnt, pixel_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver hold-off, restarted whenever hold_token toggles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt  <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_cnt  <= HOLD_CYCLES;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // result checker and output ready
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (pixel_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected pixel %02x %02x %02x", red, green, blue);
            end
            else
            begin
                head = pixel_q.pop_front();
                checked_cnt++;
                if (red !== head.px.red || green !== head.px.green
                    || blue !== head.px.blue)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch at elev %0d: exp %02x %02x %02x got %02x %02x %02x",
                                 head.elev, head.px.red, head.px.green, head.px.blue,
                                 red, green, blue);
                end
            end
        end
        out_ready <= (hold_cnt == 0)
                     && (!idle_on || $urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic send_sample(input elev_t sample);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        elevation <= sample;
        do
            @(posedge clk);
        while (!in_ready);
        pixel_q.push_back('{sample, elevation_color(sample, nodata_thr)});
        sent_cnt++;
    endtask

    // let every outstanding pixel come back, then settle
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input elev_t thr);
        drain_pipeline();
        cfg_valid <= 1'b1;
        cfg_data  <= thr;
        do
            @(posedge clk);
        while (!cfg_ready);
        nodata_thr = thr;
        cfg_cnt++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_directed_extremes();
        send_sample(-18'sd131072);
        send_sample(-18'sd90001);
        send_sample(-18'sd90000);
        send_sample(-18'sd60000);
        send_sample(-18'sd11);
        send_sample(-18'sd10);
        send_sample(-18'sd1);
        send_sample(18'sd0);
        send_sample(18'sd1);
        send_sample(18'sd199);
        send_sample(18'sd200);
        send_sample(18'sd800);
        send_sample(18'sd2999);
        send_sample(18'sd3000);
        send_sample(18'sd9000);
        send_sample(18'sd21999);
        send_sample(18'sd22000);
        send_sample(18'sd24000);
        send_sample(18'sd27000);
        send_sample(18'sd32999);
        send_sample(18'sd33000);
        send_sample(18'sd37759);
        send_sample(18'sd37760);
        send_sample(18'sd131071);
    endtask

    task automatic probe_threshold(input elev_t thr);
        int k;
        write_threshold(thr);
        for (k = -2; k <= 2; k++)
            send_sample(elev_t'(int'(thr) + k));
        send_sample(18'sd0);
        send_sample(-18'sd1);
        send_sample(18'sd1);
        send_sample(18'sd37760);
        for (k = 0; k < 20; k++)
            send_sample(rand_elevation());
    endtask

    task automatic test_nodata_thresholds();
        probe_threshold(-18'sd131072);
        probe_threshold(18'sd0);
        // positive threshold maps low land to the no-data color
        probe_threshold(18'sd500);
        probe_threshold(-18'sd1);
        probe_threshold(elev_t'(-int'($urandom_range(0, 131072))));
        probe_threshold(-18'sd90000);
    endtask

    task automatic test_random_terrain();
        int chunk;
        int n;
        for (chunk = 0; chunk < 4; chunk++)
        begin
            for (n = 0; n < 225; n++)
                send_sample(rand_elevation());
            write_threshold(elev_t'(-int'($urandom_range(0, 131072))));
        end
        write_threshold(-18'sd90000);
    endtask

    task automatic test_output_backpressure();
        int n;
        idle_on = 1'b0;
        hold_token <= ~hold_token;
        // queue and pipeline fill up, in_ready has to drop
        for (n = 0; n < 60; n++)
            send_sample(rand_elevation());
        idle_on = 1'b1;
    endtask

    task automatic test_unthrottled_burst();
        int n;
        idle_on = 1'b0;
        for (n = 0; n < 150; n++)
            send_sample(rand_elevation());
        idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        int n;
        for (n = 0; n < 30; n++)
            send_sample(rand_elevation());
        drain_pipeline();
        for (n = 0; n < 30; n++)
            send_sample(rand_elevation());
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_nodata_thresholds();
        test_random_terrain();
        test_output_backpressure();
        test_unthrottled_burst();
        test_sender_pause();

        drain_pipeline();
        $display("covered %0d elevation samples, %0d pixels checked, %0d threshold writes",
                 sent_cnt, checked_cnt, cfg_cnt);
        $display("with random idling, a %0d-cycle output hold-off and a full drain pause",
                 HOLD_CYCLES);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
